@@ rtl/nrom_cartridge_loader_and_mapper_assert.svh @@
// ----------------------------------------------------------------------------
// NROM cartridge assertion macros
// Shared assertion forms for the cartridge loader modules.
// ----------------------------------------------------------------------------
`ifndef NROM_CARTRIDGE_LOADER_AND_MAPPER_ASSERT_SVH
`define NROM_CARTRIDGE_LOADER_AND_MAPPER_ASSERT_SVH

// Check outside of reset only.
`define NCLM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check at every edge, reset included.
`define NCLM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/nclm_pkg.sv @@
// ----------------------------------------------------------------------------
// NROM cartridge package
// Codes, sizes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package nclm_pkg;

  // Sizes
  localparam int unsigned BANK_BYTES        = 16384;
  localparam int unsigned TRAINER_BYTES     = 512;
  localparam int unsigned PATTERN_BYTES     = 8192;
  localparam int unsigned WORK_RAM_BYTES    = 8192;
  localparam int unsigned HDR_BYTES         = 16;
  localparam int unsigned DEF_MAX_PRG_BANKS = 2;
  localparam int unsigned BC_W              = 16;
  localparam int unsigned PAT_AW            = $clog2(PATTERN_BYTES);
  localparam int unsigned WRAM_AW           = $clog2(WORK_RAM_BYTES);
  localparam int unsigned BANK_AW           = $clog2(BANK_BYTES);

  // Header signature
  localparam logic [7:0] SIG0 = 8'h4E;
  localparam logic [7:0] SIG1 = 8'h45;
  localparam logic [7:0] SIG2 = 8'h53;
  localparam logic [7:0] SIG3 = 8'h1A;

  // Request actions
  typedef enum logic [2:0] {
    ACT_START  = 3'd0,
    ACT_BYTE   = 3'd1,
    ACT_CPU_RD = 3'd2,
    ACT_CPU_WR = 3'd3,
    ACT_PAT_RD = 3'd4,
    ACT_PAT_WR = 3'd5
  } action_t;

  // Load progress
  typedef enum logic [2:0] {
    PH_EMPTY   = 3'd0,
    PH_HEADER  = 3'd1,
    PH_TRAINER = 3'd2,
    PH_PROGRAM = 3'd3,
    PH_PATTERN = 3'd4,
    PH_READY   = 3'd5,
    PH_FAILED  = 3'd6
  } phase_t;

  // Reported status
  typedef enum logic [2:0] {
    ST_EMPTY      = 3'd0,
    ST_LOADING    = 3'd1,
    ST_READY      = 3'd2,
    ST_BAD_SIG    = 3'd3,
    ST_BAD_MAPPER = 3'd4,
    ST_NO_PROGRAM = 3'd5,
    ST_TOO_LARGE  = 3'd6,
    ST_TRUNCATED  = 3'd7
  } status_t;

  // Nametable mirroring
  typedef enum logic [1:0] {
    MIR_HORIZ = 2'd0,
    MIR_VERT  = 2'd1,
    MIR_FOUR  = 2'd2
  } mirror_t;

  // Source of a read result
  typedef enum logic [1:0] {
    RD_NONE = 2'd0,
    RD_PRG  = 2'd1,
    RD_WRAM = 2'd2,
    RD_PAT  = 2'd3
  } rd_src_t;

  // Memory swept by a clear pass
  typedef enum logic {
    CLR_WRAM = 1'b0,
    CLR_PAT  = 1'b1
  } clr_tgt_t;

  // Controller to datapath
  typedef struct packed {
    logic exec;      // request accepted this cycle
    logic load_out;  // capture result into output register
    logic clr_en;    // clear one memory entry
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_pend;  // last request needs a clear pass
    logic clr_last;  // clear pass at final entry
  } dp_stat_t;

endpackage

@@ rtl/nclm_ctrl.sv @@
// ----------------------------------------------------------------------------
// NROM cartridge controller
// Sequences request accept, result capture and memory clear passes.
// ----------------------------------------------------------------------------
`include "nrom_cartridge_loader_and_mapper_assert.svh"

module nclm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output nclm_pkg::ctrl_cmd_t cmd,
  input  nclm_pkg::dp_stat_t  stat
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_READ  = 3'b010,
    S_CLEAR = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Accept only when idle and the output register is free or draining
  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  assign cmd.exec     = in_valid && in_ready;
  assign cmd.load_out = (state_r == S_READ);
  assign cmd.clr_en   = (state_r == S_CLEAR);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.exec) state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = stat.clr_pend ? S_CLEAR : S_IDLE;
      end
      S_CLEAR: begin
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold result until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `NCLM_ASSERT(a_accept_to_read, (in_valid && in_ready) |=> (state_r == S_READ), "accept did not start read")
  `NCLM_ASSERT(a_read_gives_out, (state_r == S_READ) |=> out_valid, "read did not produce result")
  `NCLM_ASSERT(a_out_from_read, $rose(out_valid) |-> $past(state_r == S_READ), "result without read")
  `NCLM_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == S_IDLE && !out_valid_r), "reset not idle")

endmodule

@@ rtl/nclm_dp.sv @@
// ----------------------------------------------------------------------------
// NROM cartridge datapath
// Header check, load tracking, program/pattern/work memories and result.
// ----------------------------------------------------------------------------
`include "nrom_cartridge_loader_and_mapper_assert.svh"

module nclm_dp #(
  parameter int unsigned MAX_PROGRAM_BANKS = nclm_pkg::DEF_MAX_PRG_BANKS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  nclm_pkg::ctrl_cmd_t cmd,
  output nclm_pkg::dp_stat_t  stat,
  input  logic [2:0]          in_action,
  input  logic [15:0]         in_address,
  input  logic [7:0]          in_data,
  input  logic                in_last,
  output logic [7:0]          out_read_data,
  output logic [2:0]          out_status,
  output logic [1:0]          out_mirroring,
  output logic                out_pattern_is_ram,
  output logic [1:0]          out_program_banks
);

  localparam int unsigned PRG_BYTES = MAX_PROGRAM_BANKS * nclm_pkg::BANK_BYTES;
  localparam int unsigned PRG_AW    = $clog2(PRG_BYTES);
  localparam int unsigned BC_W      = nclm_pkg::BC_W;
  localparam int unsigned PAT_AW    = nclm_pkg::PAT_AW;
  localparam int unsigned WRAM_AW   = nclm_pkg::WRAM_AW;

  // Load and mapping state
  nclm_pkg::phase_t   phase_r, phase_nxt;
  nclm_pkg::status_t  status_r, status_nxt;
  nclm_pkg::mirror_t  mirror_r, mirror_nxt;
  nclm_pkg::rd_src_t  rd_src_r, rd_src_nxt;
  nclm_pkg::clr_tgt_t clr_tgt_r, clr_tgt_nxt;
  logic [BC_W-1:0]    bc_r, bc_nxt, bc_inc;
  logic               pram_r, pram_nxt;
  logic [1:0]         banks_r, banks_nxt;
  logic               clr_pend_r, clr_pend_nxt;
  logic [PAT_AW-1:0]  clr_cnt_r;
  logic [7:0]         hdr_r [nclm_pkg::HDR_BYTES];

  // Header decode
  logic sig_ok, mapper_bad, prg_zero, too_large;
  logic ready, loading_nxt;
  logic [BC_W-1:0] prg_end;

  // Memory controls
  logic hdr_we, prg_we, pat_we_ld, pat_we_bus, wram_we_bus;
  logic pat_we, wram_we;
  logic [PAT_AW-1:0]  pat_waddr;
  logic [WRAM_AW-1:0] wram_waddr;
  logic [7:0]         pat_wdata, wram_wdata;
  logic [PRG_AW-1:0]  prg_mask, prg_raddr;
  logic [BC_W-1:0]    prg_span;

  logic [7:0] prg_mem  [PRG_BYTES];
  logic [7:0] pat_mem  [nclm_pkg::PATTERN_BYTES];
  logic [7:0] wram_mem [nclm_pkg::WORK_RAM_BYTES];
  logic [7:0] prg_rd_r, pat_rd_r, wram_rd_r;
  logic [7:0] rd_mux;

  assign ready  = (phase_r == nclm_pkg::PH_READY);
  assign bc_inc = bc_r + BC_W'(1);

  // Program span in bytes for the loaded bank count
  assign prg_end = {banks_r, {nclm_pkg::BANK_AW{1'b0}}};

  // Header checks on bytes 0 to 8
  assign sig_ok = (hdr_r[0] == nclm_pkg::SIG0) && (hdr_r[1] == nclm_pkg::SIG1) &&
                  (hdr_r[2] == nclm_pkg::SIG2) && (hdr_r[3] == nclm_pkg::SIG3);
  assign mapper_bad = (hdr_r[6][7:4] != 4'd0) ||
                      ((hdr_r[7][3:2] == 2'b10) &&
                       ((hdr_r[7][7:4] != 4'd0) || (hdr_r[8][3:0] != 4'd0))) ||
                      ((hdr_r[7][3:2] == 2'b00) && (hdr_r[7][7:4] != 4'd0));
  assign prg_zero  = (hdr_r[4] == 8'd0);
  assign too_large = (hdr_r[4] > 8'(MAX_PROGRAM_BANKS)) || (hdr_r[5] > 8'd1);

  // Request execution
  always_comb begin
    phase_nxt    = phase_r;
    status_nxt   = status_r;
    mirror_nxt   = mirror_r;
    pram_nxt     = pram_r;
    banks_nxt    = banks_r;
    bc_nxt       = bc_r;
    clr_pend_nxt = clr_pend_r;
    clr_tgt_nxt  = clr_tgt_r;
    rd_src_nxt   = rd_src_r;
    hdr_we       = 1'b0;
    prg_we       = 1'b0;
    pat_we_ld    = 1'b0;
    pat_we_bus   = 1'b0;
    wram_we_bus  = 1'b0;
    loading_nxt  = 1'b0;
    if (cmd.exec) begin
      clr_pend_nxt = 1'b0;
      rd_src_nxt   = nclm_pkg::RD_NONE;
      case (in_action)
        nclm_pkg::ACT_START: begin
          phase_nxt    = nclm_pkg::PH_HEADER;
          status_nxt   = nclm_pkg::ST_LOADING;
          bc_nxt       = '0;
          mirror_nxt   = nclm_pkg::MIR_HORIZ;
          pram_nxt     = 1'b0;
          banks_nxt    = 2'd0;
          clr_pend_nxt = 1'b1;
          clr_tgt_nxt  = nclm_pkg::CLR_WRAM;
        end
        nclm_pkg::ACT_BYTE: begin
          case (phase_r)
            nclm_pkg::PH_HEADER: begin
              hdr_we = 1'b1;
              bc_nxt = bc_inc;
              // Sixteenth byte: run the header checks in order
              if (bc_r[3:0] == 4'hF) begin
                if (!sig_ok) begin
                  phase_nxt  = nclm_pkg::PH_FAILED;
                  status_nxt = nclm_pkg::ST_BAD_SIG;
                end else if (mapper_bad) begin
                  phase_nxt  = nclm_pkg::PH_FAILED;
                  status_nxt = nclm_pkg::ST_BAD_MAPPER;
                end else if (prg_zero) begin
                  phase_nxt  = nclm_pkg::PH_FAILED;
                  status_nxt = nclm_pkg::ST_NO_PROGRAM;
                end else if (too_large) begin
                  phase_nxt  = nclm_pkg::PH_FAILED;
                  status_nxt = nclm_pkg::ST_TOO_LARGE;
                end else begin
                  banks_nxt = hdr_r[4][1:0];
                  if (hdr_r[6][3]) begin
                    mirror_nxt = nclm_pkg::MIR_FOUR;
                  end else if (hdr_r[6][0]) begin
                    mirror_nxt = nclm_pkg::MIR_VERT;
                  end else begin
                    mirror_nxt = nclm_pkg::MIR_HORIZ;
                  end
                  if (hdr_r[5] == 8'd0) begin
                    pram_nxt     = 1'b1;
                    clr_pend_nxt = 1'b1;
                    clr_tgt_nxt  = nclm_pkg::CLR_PAT;
                  end
                  bc_nxt    = '0;
                  phase_nxt = hdr_r[6][2] ? nclm_pkg::PH_TRAINER : nclm_pkg::PH_PROGRAM;
                end
              end
            end
            nclm_pkg::PH_TRAINER: begin
              bc_nxt = bc_inc;
              if (bc_inc >= BC_W'(nclm_pkg::TRAINER_BYTES)) begin
                bc_nxt    = '0;
                phase_nxt = nclm_pkg::PH_PROGRAM;
              end
            end
            nclm_pkg::PH_PROGRAM: begin
              prg_we = 1'b1;
              bc_nxt = bc_inc;
              if (bc_inc >= prg_end) begin
                bc_nxt = '0;
                if (pram_r) begin
                  phase_nxt  = nclm_pkg::PH_READY;
                  status_nxt = nclm_pkg::ST_READY;
                end else begin
                  phase_nxt = nclm_pkg::PH_PATTERN;
                end
              end
            end
            nclm_pkg::PH_PATTERN: begin
              pat_we_ld = 1'b1;
              bc_nxt    = bc_inc;
              if (bc_inc >= BC_W'(nclm_pkg::PATTERN_BYTES)) begin
                phase_nxt  = nclm_pkg::PH_READY;
                status_nxt = nclm_pkg::ST_READY;
              end
            end
            default: ;
          endcase
          // Last mark while still loading: drop the cartridge
          loading_nxt = (phase_nxt == nclm_pkg::PH_HEADER) ||
                        (phase_nxt == nclm_pkg::PH_TRAINER) ||
                        (phase_nxt == nclm_pkg::PH_PROGRAM) ||
                        (phase_nxt == nclm_pkg::PH_PATTERN);
          if (in_last && loading_nxt) begin
            phase_nxt    = nclm_pkg::PH_FAILED;
            status_nxt   = nclm_pkg::ST_TRUNCATED;
            clr_pend_nxt = 1'b0;
          end
          // Any failure drops the mapping info
          if (phase_nxt == nclm_pkg::PH_FAILED) begin
            mirror_nxt = nclm_pkg::MIR_HORIZ;
            pram_nxt   = 1'b0;
            banks_nxt  = 2'd0;
          end
        end
        nclm_pkg::ACT_CPU_RD: begin
          if (ready) begin
            if (in_address[15]) begin
              rd_src_nxt = nclm_pkg::RD_PRG;
            end else if (in_address[14:13] == 2'b11) begin
              rd_src_nxt = nclm_pkg::RD_WRAM;
            end
          end
        end
        nclm_pkg::ACT_CPU_WR: begin
          wram_we_bus = ready && (in_address[15:13] == 3'b011);
        end
        nclm_pkg::ACT_PAT_RD: begin
          if (ready) rd_src_nxt = nclm_pkg::RD_PAT;
        end
        nclm_pkg::ACT_PAT_WR: begin
          pat_we_bus = ready && pram_r;
        end
        default: ;
      endcase
    end
  end

  // Load state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= nclm_pkg::PH_EMPTY;
      status_r   <= nclm_pkg::ST_EMPTY;
      mirror_r   <= nclm_pkg::MIR_HORIZ;
      pram_r     <= 1'b0;
      banks_r    <= 2'd0;
      bc_r       <= '0;
      clr_pend_r <= 1'b0;
      clr_tgt_r  <= nclm_pkg::CLR_WRAM;
      rd_src_r   <= nclm_pkg::RD_NONE;
    end else begin
      phase_r    <= phase_nxt;
      status_r   <= status_nxt;
      mirror_r   <= mirror_nxt;
      pram_r     <= pram_nxt;
      banks_r    <= banks_nxt;
      bc_r       <= bc_nxt;
      clr_pend_r <= clr_pend_nxt;
      clr_tgt_r  <= clr_tgt_nxt;
      rd_src_r   <= rd_src_nxt;
    end
  end

  // Header byte capture
  always_ff @(posedge clk) begin
    if (hdr_we) hdr_r[bc_r[3:0]] <= in_data;
  end

  // Clear pass address counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt_r <= clr_cnt_r + PAT_AW'(1);
    end
  end

  assign stat.clr_pend = clr_pend_r;
  assign stat.clr_last = (clr_cnt_r == {PAT_AW{1'b1}});

  // Program memory: fill write, masked read
  assign prg_span  = prg_end - BC_W'(1);
  assign prg_mask  = prg_span[PRG_AW-1:0];
  assign prg_raddr = in_address[PRG_AW-1:0] & prg_mask;

  always_ff @(posedge clk) begin
    if (prg_we) prg_mem[bc_r[PRG_AW-1:0]] <= in_data;
    prg_rd_r <= prg_mem[prg_raddr];
  end

  // Pattern memory: load fill, bus write or clear
  assign pat_we    = pat_we_ld || pat_we_bus ||
                     (cmd.clr_en && (clr_tgt_r == nclm_pkg::CLR_PAT));
  assign pat_waddr = cmd.clr_en ? clr_cnt_r :
                     (pat_we_ld ? bc_r[PAT_AW-1:0] : in_address[PAT_AW-1:0]);
  assign pat_wdata = cmd.clr_en ? 8'd0 : in_data;

  always_ff @(posedge clk) begin
    if (pat_we) pat_mem[pat_waddr] <= pat_wdata;
    pat_rd_r <= pat_mem[in_address[PAT_AW-1:0]];
  end

  // Work RAM: bus write or clear
  assign wram_we    = wram_we_bus || (cmd.clr_en && (clr_tgt_r == nclm_pkg::CLR_WRAM));
  assign wram_waddr = cmd.clr_en ? clr_cnt_r : in_address[WRAM_AW-1:0];
  assign wram_wdata = cmd.clr_en ? 8'd0 : in_data;

  always_ff @(posedge clk) begin
    if (wram_we) wram_mem[wram_waddr] <= wram_wdata;
    wram_rd_r <= wram_mem[in_address[WRAM_AW-1:0]];
  end

  // Select read byte
  always_comb begin
    unique case (rd_src_r)
      nclm_pkg::RD_PRG:  rd_mux = prg_rd_r;
      nclm_pkg::RD_WRAM: rd_mux = wram_rd_r;
      nclm_pkg::RD_PAT:  rd_mux = pat_rd_r;
      default:           rd_mux = 8'd0;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_read_data      <= rd_mux;
      out_status         <= status_r;
      out_mirroring      <= mirror_r;
      out_pattern_is_ram <= pram_r;
      out_program_banks  <= banks_r;
    end
  end

  `NCLM_ASSERT(a_ready_match, (status_r == nclm_pkg::ST_READY) == (phase_r == nclm_pkg::PH_READY), "status and phase disagree")
  `NCLM_ASSERT(a_ready_banks, (phase_r == nclm_pkg::PH_READY) |-> (banks_r != 2'd0), "ready without program banks")
  `NCLM_ASSERT(a_clear_alone, cmd.clr_en |-> !(cmd.exec || cmd.load_out), "clear overlaps request")

endmodule

@@ rtl/nrom_cartridge_loader_and_mapper.sv @@
// ----------------------------------------------------------------------------
// NROM cartridge loader and mapper
// Loads an iNES mapper-0 image and serves CPU and pattern-bus accesses.
// ----------------------------------------------------------------------------
// Every request gives one result. A request is accepted only while the
// controller is idle, its memory read is registered, and the result is then
// captured in the output register; no new request is accepted before that.
// A start-load request is followed by a clear pass over the 8192-byte work
// RAM, and a header that declares no pattern ROM is followed by a clear pass
// over the 8192-byte pattern RAM, one entry per cycle on the memory's single
// write port; no request is accepted until it ends. Results already produced
// can still be taken during a pass.

module nrom_cartridge_loader_and_mapper #(
  parameter int unsigned MAX_PROGRAM_BANKS = nclm_pkg::DEF_MAX_PRG_BANKS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_action,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_data,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data,
  output logic [2:0]  out_status,
  output logic [1:0]  out_mirroring,
  output logic        out_pattern_is_ram,
  output logic [1:0]  out_program_banks
);

  nclm_pkg::ctrl_cmd_t cmd;
  nclm_pkg::dp_stat_t  stat;

  // Sequencer
  nclm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Loader, memories and result
  nclm_dp #(
    .MAX_PROGRAM_BANKS (MAX_PROGRAM_BANKS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_action          (in_action),
    .in_address         (in_address),
    .in_data            (in_data),
    .in_last            (in_last),
    .out_read_data      (out_read_data),
    .out_status         (out_status),
    .out_mirroring      (out_mirroring),
    .out_pattern_is_ram (out_pattern_is_ram),
    .out_program_banks  (out_program_banks)
  );

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// NROM cartridge loader and mapper testbench
// Streams cartridge images (good, malformed and cut short) into the block,
// then mixes CPU and pattern-bus requests with random content. A built-in
// cartridge model predicts each result, and a checker compares every field
// in order. Sender bursts, receiver stalls and long hold-offs vary the timing.
// ----------------------------------------------------------------------------
module testbench;
  import nclm_pkg::*;

  localparam int unsigned MAX_BANKS    = DEF_MAX_PRG_BANKS;
  localparam int unsigned PRG_BYTES    = MAX_BANKS * BANK_BYTES;
  localparam int unsigned CYCLE_LIMIT  = 4000000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned TAIL_CYCLES  = 50;
  localparam int unsigned MAX_REPORTS  = 40;
  localparam logic [2:0]  ACT_UNDEF_6  = 3'd6;
  localparam logic [2:0]  ACT_UNDEF_7  = 3'd7;

  typedef struct packed {
    logic [7:0] rd;
    status_t    st;
    mirror_t    mir;
    logic       ram;
    logic [1:0] banks;
  } cart_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_action = '0;
  logic [15:0] in_address = '0;
  logic [7:0]  in_data = '0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_read_data;
  logic [2:0]  out_status;
  logic [1:0]  out_mirroring;
  logic        out_pattern_is_ram;
  logic [1:0]  out_program_banks;

  // Cartridge model state
  phase_t      cart_phase;
  status_t     load_st;
  mirror_t     mir;
  logic        pat_ram;
  logic [1:0]  banks;
  int unsigned load_cnt;
  logic [7:0]  hdr_mem [HDR_BYTES];
  logic [7:0]  prg_mem [PRG_BYTES];
  logic [7:0]  pat_mem [PATTERN_BYTES];
  logic [7:0]  wram    [WORK_RAM_BYTES];

  cart_result_t pending_results [$];
  cart_result_t want_res;
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;
  int           burst_left = 0;

  // Receiver stall control
  int unsigned  rx_cycle = 0;
  int unsigned  hold_left = 0;
  int unsigned  hold_asked = 0;
  int unsigned  hold_seen = 0;

  nrom_cartridge_loader_and_mapper #(
    .MAX_PROGRAM_BANKS(MAX_BANKS)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_address        (in_address),
    .in_data           (in_data),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_read_data     (out_read_data),
    .out_status        (out_status),
    .out_mirroring     (out_mirroring),
    .out_pattern_is_ram(out_pattern_is_ram),
    .out_program_banks (out_program_banks)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Cartridge model
  // ---------------------------------------------------------------------------

  // Return the model to its power-up state
  task automatic clear_cartridge();
    cart_phase = PH_EMPTY;
    load_st    = ST_EMPTY;
    mir        = MIR_HORIZ;
    pat_ram    = 1'b0;
    banks      = '0;
    load_cnt   = 0;
    for (int i = 0; i < HDR_BYTES; i++) hdr_mem[i] = 8'h00;
    for (int i = 0; i < PRG_BYTES; i++) prg_mem[i] = 8'h00;
    for (int i = 0; i < PATTERN_BYTES; i++) pat_mem[i] = 8'h00;
    for (int i = 0; i < WORK_RAM_BYTES; i++) wram[i] = 8'h00;
  endtask

  // Drop the mapping info and latch the failure code
  task automatic fail_load(input status_t code);
    cart_phase = PH_FAILED;
    load_st    = code;
    mir        = MIR_HORIZ;
    pat_ram    = 1'b0;
    banks      = '0;
  endtask

  task automatic finish_load();
    cart_phase = PH_READY;
    load_st    = ST_READY;
  endtask

  // Validate the 16-byte header in the order signature, mapper, size
  task automatic check_header();
    int unsigned mapper;
    int unsigned prg;
    int unsigned chr;
    logic [7:0]  f6;
    logic [7:0]  f7;
    logic [7:0]  f8;
    f6 = hdr_mem[6];
    f7 = hdr_mem[7];
    f8 = hdr_mem[8];
    prg = hdr_mem[4];
    chr = hdr_mem[5];
    mapper = f6[7:4];
    if (f7[3:2] == 2'b10)
      mapper = mapper | {f8[3:0], f7[7:4], 4'h0};
    else if (f7[3:2] == 2'b00)
      mapper = mapper | {f7[7:4], 4'h0};
    if (hdr_mem[0] != SIG0 || hdr_mem[1] != SIG1 ||
        hdr_mem[2] != SIG2 || hdr_mem[3] != SIG3) begin
      fail_load(ST_BAD_SIG);
    end else if (mapper != 0) begin
      fail_load(ST_BAD_MAPPER);
    end else if (prg == 0) begin
      fail_load(ST_NO_PROGRAM);
    end else if (prg > MAX_BANKS || chr > 1) begin
      fail_load(ST_TOO_LARGE);
    end else begin
      banks = prg[1:0];
      if (f6[3])
        mir = MIR_FOUR;
      else if (f6[0])
        mir = MIR_VERT;
      else
        mir = MIR_HORIZ;
      if (chr == 0) begin
        pat_ram = 1'b1;
        for (int i = 0; i < PATTERN_BYTES; i++) pat_mem[i] = 8'h00;
      end
      load_cnt = 0;
      cart_phase = f6[2] ? PH_TRAINER : PH_PROGRAM;
    end
  endtask

  // Consume one image byte in the current load phase
  task automatic take_image_byte(input logic [7:0] d);
    case (cart_phase)
      PH_HEADER: begin
        hdr_mem[load_cnt % HDR_BYTES] = d;
        load_cnt++;
        if (load_cnt >= HDR_BYTES) check_header();
      end
      PH_TRAINER: begin
        load_cnt++;
        if (load_cnt >= TRAINER_BYTES) begin
          load_cnt = 0;
          cart_phase = PH_PROGRAM;
        end
      end
      PH_PROGRAM: begin
        if (load_cnt < PRG_BYTES) prg_mem[load_cnt] = d;
        load_cnt++;
        if (load_cnt >= banks * BANK_BYTES) begin
          load_cnt = 0;
          if (pat_ram)
            finish_load();
          else
            cart_phase = PH_PATTERN;
        end
      end
      PH_PATTERN: begin
        pat_mem[load_cnt % PATTERN_BYTES] = d;
        load_cnt++;
        if (load_cnt >= PATTERN_BYTES) finish_load();
      end
      default: ;
    endcase
  endtask

  // Advance the model by one accepted request and queue its result
  task automatic apply_request(input logic [2:0] act, input logic [15:0] addr,
                               input logic [7:0] data, input logic last);
    cart_result_t r;
    logic [7:0]   rd;
    bit           ready;
    int unsigned  span;
    int unsigned  off;
    rd = 8'h00;
    ready = (cart_phase == PH_READY);
    case (act)
      ACT_START: begin
        cart_phase = PH_HEADER;
        load_st    = ST_LOADING;
        load_cnt   = 0;
        mir        = MIR_HORIZ;
        pat_ram    = 1'b0;
        banks      = '0;
        for (int i = 0; i < WORK_RAM_BYTES; i++) wram[i] = 8'h00;
      end
      ACT_BYTE: begin
        if (cart_phase >= PH_HEADER && cart_phase <= PH_PATTERN) begin
          take_image_byte(data);
          if (last && cart_phase >= PH_HEADER && cart_phase <= PH_PATTERN)
            fail_load(ST_TRUNCATED);
        end
      end
      ACT_CPU_RD: begin
        if (ready) begin
          if (addr >= 16'h8000) begin
            span = banks * BANK_BYTES;
            off = (32'(addr) - 32'h8000) & (span - 1);
            if (off < PRG_BYTES) rd = prg_mem[off];
          end else if (addr >= 16'h6000) begin
            rd = wram[(32'(addr) - 32'h6000) & (WORK_RAM_BYTES - 1)];
          end
        end
      end
      ACT_CPU_WR: begin
        if (ready && addr >= 16'h6000 && addr < 16'h8000)
          wram[(32'(addr) - 32'h6000) & (WORK_RAM_BYTES - 1)] = data;
      end
      ACT_PAT_RD: begin
        if (ready) rd = pat_mem[addr & (PATTERN_BYTES - 1)];
      end
      ACT_PAT_WR: begin
        if (ready && pat_ram) pat_mem[addr & (PATTERN_BYTES - 1)] = data;
      end
      default: ;
    endcase
    r.rd    = rd;
    r.st    = load_st;
    r.mir   = mir;
    r.ram   = pat_ram;
    r.banks = banks;
    pending_results.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one request, idling between bursts, and model it once accepted
  task automatic issue_request(input logic [2:0] act, input logic [15:0] addr,
                               input logic [7:0] data, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_action  <= act;
    in_address <= addr;
    in_data    <= data;
    in_last    <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_request(act, addr, data, last);
  endtask

  // Hold the sender until every pending result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Ask the receiver for one long hold-off
  task automatic request_hold();
    hold_asked <= hold_asked + 1;
  endtask

  // Build a header with a good signature and random filler bytes
  function automatic logic [127:0] make_header(input logic [7:0] prg, input logic [7:0] chr,
                                               input logic [7:0] f6, input logic [7:0] f7,
                                               input logic [7:0] f8);
    logic [127:0] h;
    h = {$urandom, $urandom, $urandom, $urandom};
    h[7:0]   = SIG0;
    h[15:8]  = SIG1;
    h[23:16] = SIG2;
    h[31:24] = SIG3;
    h[39:32] = prg;
    h[47:40] = chr;
    h[55:48] = f6;
    h[63:56] = f7;
    h[71:64] = f8;
    return h;
  endfunction

  // Start a load and stream the first header bytes, marking at most one as last
  task automatic run_header(input logic [127:0] hdr, input int last_at, input int n_bytes);
    logic [15:0] a;
    a = $urandom;
    issue_request(ACT_START, a, 8'($urandom), 1'($urandom));
    for (int b = 0; b < n_bytes; b++) begin
      a = $urandom;
      issue_request(ACT_BYTE, a, hdr[8*b +: 8], b == last_at);
    end
  endtask

  // Stream image bytes, probing the bus now and then while loading
  task automatic issue_image(input int count, input bit last_at_end, input int probe_every);
    logic [15:0] a;
    logic [7:0]  d;
    for (int n = 0; n < count; n++) begin
      a = $urandom;
      d = $urandom;
      if (probe_every != 0 && n % probe_every == probe_every / 2)
        issue_request(n[0] ? ACT_PAT_RD : ACT_CPU_RD, a, d, 1'b0);
      issue_request(ACT_BYTE, a, d, last_at_end && (n == count - 1));
    end
  endtask

  // Follow a failed load: image bytes are ignored, reads give zero
  task automatic probe_after_failure();
    issue_request(ACT_BYTE, 16'h0000, 8'($urandom), 1'b1);
    issue_request(ACT_CPU_RD, 16'h8000, 8'h00, 1'b0);
    issue_request(ACT_PAT_RD, 16'h1FFF, 8'h00, 1'b0);
  endtask

  // Random bus traffic with a little noise mixed in
  task automatic issue_random_traffic(input int count);
    int          sel;
    logic [2:0]  act;
    logic [15:0] a;
    logic [7:0]  d;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(0, 99);
      a = $urandom;
      d = $urandom;
      // Narrow half the addresses so reads land on recent writes
      if ($urandom_range(0, 1)) a[12:6] = '0;
      if (sel < 25) begin
        act = ACT_CPU_RD;
      end else if (sel < 40) begin
        act = ACT_CPU_RD;
        a[15:13] = 3'b011;
      end else if (sel < 58) begin
        act = ACT_CPU_WR;
        if (sel < 53) a[15:13] = 3'b011;
      end else if (sel < 75) begin
        act = ACT_PAT_RD;
      end else if (sel < 88) begin
        act = ACT_PAT_WR;
      end else if (sel < 94) begin
        act = ACT_BYTE;
      end else begin
        act = sel[0] ? ACT_UNDEF_6 : ACT_UNDEF_7;
      end
      issue_request(act, a, d, 1'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Access an empty cartridge slot
  task automatic test_unloaded_access();
    issue_request(ACT_CPU_RD, 16'hFFFF, 8'hFF, 1'b1);
    issue_request(ACT_CPU_WR, 16'h6000, 8'hFF, 1'b0);
    issue_request(ACT_CPU_RD, 16'h6000, 8'h00, 1'b0);
    issue_request(ACT_PAT_WR, 16'h0000, 8'hFF, 1'b0);
    issue_request(ACT_PAT_RD, 16'h0000, 8'h00, 1'b0);
    issue_request(ACT_BYTE, 16'hFFFF, 8'h4E, 1'b1);
    issue_request(ACT_UNDEF_6, 16'hFFFF, 8'hFF, 1'b1);
    issue_request(ACT_UNDEF_7, 16'h0000, 8'h00, 1'b0);
  endtask

  // Walk the header check order and each kind of short image
  task automatic test_header_checks();
    logic [127:0] h;
    // bad signature, with a bad mapper behind it
    h = make_header(8'd1, 8'd1, 8'h10, 8'h00, 8'h00);
    h[8*$urandom_range(0, 3) +: 8] = 8'h00;
    run_header(h, -1, 16);
    probe_after_failure();
    h = make_header(8'd1, 8'd1, 8'h00, 8'h00, 8'h00);
    h[31:24] = 8'h1B;
    run_header(h, -1, 16);
    // mapper from each header byte
    run_header(make_header(8'd1, 8'd1, 8'hF0, 8'h00, 8'h00), -1, 16);
    probe_after_failure();
    run_header(make_header(8'd1, 8'd1, 8'h00, 8'h10, 8'h00), -1, 16);
    run_header(make_header(8'd1, 8'd1, 8'h00, 8'h08, 8'h01), -1, 16);
    // no program banks outranks too large
    run_header(make_header(8'd0, 8'd5, 8'h00, 8'h00, 8'h00), -1, 16);
    probe_after_failure();
    run_header(make_header(8'd3, 8'd0, 8'h00, 8'h00, 8'h00), -1, 16);
    run_header(make_header(8'd1, 8'd2, 8'h00, 8'h00, 8'h00), -1, 16);
    run_header(make_header(8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00), -1, 16);
    // last mark on the final header byte: header error wins, else truncated
    run_header(make_header(8'd1, 8'd1, 8'h20, 8'h00, 8'h00), 15, 16);
    run_header(make_header(8'd1, 8'd1, 8'h01, 8'h00, 8'h00), 15, 16);
    probe_after_failure();
    // cut short in the header, the trainer and the program data
    run_header(make_header(8'd1, 8'd1, 8'h00, 8'h00, 8'h00), 7, 8);
    probe_after_failure();
    run_header(make_header(8'd1, 8'd1, 8'h05, 8'h00, 8'h00), -1, 16);
    issue_image(10, 1'b1, 0);
    probe_after_failure();
    run_header(make_header(8'd2, 8'd1, 8'h00, 8'hFC, 8'hFF), -1, 16);
    issue_image(20, 1'b1, 0);
    probe_after_failure();
  endtask

  // Load two program banks and a pattern ROM, then poke the map
  task automatic test_rom_cartridge();
    run_header(make_header(8'd2, 8'd1, 8'h09, 8'h08, 8'hF0), -1, 16);
    // Stall the receiver while the image keeps coming
    request_hold();
    issue_image(2 * BANK_BYTES, 1'b0, 4096);
    issue_image(PATTERN_BYTES, 1'b1, 2048);
    // Trailing image bytes leave the cartridge ready
    issue_request(ACT_BYTE, 16'h1234, 8'hAA, 1'b1);
    issue_request(ACT_BYTE, 16'h4321, 8'h55, 1'b0);
    issue_request(ACT_CPU_RD, 16'h8000, 8'h00, 1'b0);
    issue_request(ACT_CPU_RD, 16'hBFFF, 8'h00, 1'b0);
    issue_request(ACT_CPU_RD, 16'hC000, 8'h00, 1'b0);
    issue_request(ACT_CPU_RD, 16'hFFFF, 8'h00, 1'b0);
    issue_request(ACT_CPU_WR, 16'h6000, 8'hA5, 1'b0);
    issue_request(ACT_CPU_WR, 16'h7FFF, 8'h5A, 1'b0);
    issue_request(ACT_CPU_RD, 16'h6000, 8'h00, 1'b0);
    issue_request(ACT_CPU_RD, 16'h7FFF, 8'h00, 1'b0);
    issue_request(ACT_CPU_WR, 16'h5FFF, 8'hFF, 1'b0);
    issue_request(ACT_CPU_RD, 16'h5FFF, 8'h00, 1'b0);
    issue_request(ACT_CPU_RD, 16'h0000, 8'h00, 1'b0);
    issue_request(ACT_CPU_WR, 16'h8000, 8'hFF, 1'b0);
    issue_request(ACT_CPU_RD, 16'h8000, 8'h00, 1'b0);
    issue_request(ACT_PAT_WR, 16'h0000, 8'hFF, 1'b0);
    issue_request(ACT_PAT_RD, 16'h0000, 8'h00, 1'b0);
    issue_request(ACT_PAT_RD, 16'h1FFF, 8'h00, 1'b0);
    issue_request(ACT_PAT_RD, 16'hFFFF, 8'h00, 1'b0);
    issue_request(ACT_UNDEF_6, 16'h6000, 8'hFF, 1'b0);
    issue_request(ACT_UNDEF_7, 16'h8000, 8'hFF, 1'b1);
  endtask

  // Random traffic on the ROM cartridge, with a full pause midway
  task automatic test_random_rom();
    request_hold();
    issue_random_traffic(110);
    drain_results();
    issue_random_traffic(110);
  endtask

  // Load one program bank behind a trainer, with pattern RAM
  task automatic test_ram_cartridge();
    run_header(make_header(8'd1, 8'd0, 8'h05, 8'hF4, 8'hFF), -1, 16);
    issue_image(TRAINER_BYTES, 1'b0, 0);
    issue_image(BANK_BYTES, 1'b1, 4096);
    issue_request(ACT_BYTE, 16'h0000, 8'h00, 1'b1);
    issue_request(ACT_PAT_RD, 16'h0123, 8'h00, 1'b0);
    issue_request(ACT_PAT_WR, 16'h1FFF, 8'hC3, 1'b0);
    issue_request(ACT_PAT_RD, 16'h1FFF, 8'h00, 1'b0);
    issue_request(ACT_PAT_RD, 16'hFFFF, 8'h00, 1'b0);
    issue_request(ACT_CPU_RD, 16'h8000, 8'h00, 1'b0);
    issue_request(ACT_CPU_RD, 16'hC000, 8'h00, 1'b0);
    issue_request(ACT_CPU_RD, 16'hFFFF, 8'h00, 1'b0);
    issue_request(ACT_CPU_RD, 16'h6000, 8'h00, 1'b0);
  endtask

  task automatic test_random_ram();
    issue_random_traffic(220);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and checking
  // ---------------------------------------------------------------------------

  // Count and print one mismatch, quietly past the report cap
  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("MISMATCH: %s", msg);
  endtask

  // Stall the result channel on a rotating pattern, or hold off on request
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_seen) begin
      hold_seen <= hold_asked;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      case ((rx_cycle / 97) % 4)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 3) != 0);
        2:       out_ready <= (rx_cycle % 3 == 0);
        default: out_ready <= 1'($urandom);
      endcase
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result rd=%0d st=%0d", out_read_data, out_status));
      end else begin
        want_res = pending_results.pop_front();
        if (out_read_data !== want_res.rd || out_status !== want_res.st ||
            out_mirroring !== want_res.mir || out_pattern_is_ram !== want_res.ram ||
            out_program_banks !== want_res.banks)
          flag_mismatch($sformatf(
            "rd %0d/%0d st %0d/%0d mir %0d/%0d ram %0d/%0d banks %0d/%0d (got/want)",
            out_read_data, want_res.rd, out_status, want_res.st,
            out_mirroring, want_res.mir, out_pattern_is_ram, want_res.ram,
            out_program_banks, want_res.banks));
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** nrom_cartridge_loader_and_mapper: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    clear_cartridge();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_unloaded_access();
    test_header_checks();
    test_rom_cartridge();
    test_random_rom();
    test_ram_cartridge();
    test_random_ram();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("** nrom_cartridge_loader_and_mapper: PASSED **");
    else
      $display("** nrom_cartridge_loader_and_mapper: FAILED **");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/nclm_pkg.sv
rtl/nclm_ctrl.sv
rtl/nclm_dp.sv
rtl/nrom_cartridge_loader_and_mapper.sv
dv/testbench.sv
